// ===== rtl/ncc_pkg.sv =====
`default_nettype none
package ncc_pkg;

	// default sizes
	localparam int DEF_MAX_TEMPLATE_ROWS = 64;
	localparam int DEF_MAX_TEMPLATE_COLS = 64;
	localparam int DEF_MAX_IMAGE_ROWS    = 256;
	localparam int DEF_MAX_IMAGE_COLS    = 256;
	localparam int DEF_WINDOW_RADIUS     = 2;

	// fixed field and coordinate widths, score scale and shift
	localparam int CW        = 11;
	localparam int CFG_DW    = 9;
	localparam int SCORE_ONE = 32768;
	localparam int RHS_SHIFT = 30;

	// command codes
	localparam logic [1:0] CMD_TMPL   = 2'd0;
	localparam logic [1:0] CMD_IMG    = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// register indexes
	localparam logic [1:0] CFG_TROWS = 2'd0;
	localparam logic [1:0] CFG_TCOLS = 2'd1;
	localparam logic [1:0] CFG_IROWS = 2'd2;
	localparam logic [1:0] CFG_ICOLS = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] pixel;
		logic [7:0] hint_row;
		logic [7:0] hint_col;
	} ncc_in_t;

	typedef struct packed {
		logic [7:0]  best_row;
		logic [7:0]  best_col;
		logic [7:0]  center_row;
		logic [7:0]  center_col;
		logic [15:0] best_score;
	} ncc_out_t;

	typedef enum logic [3:0] {
		MUL_N_STT,
		MUL_ST_ST,
		MUL_N_SII,
		MUL_SI_SI,
		MUL_N_STI,
		MUL_ST_SI,
		MUL_VT_VI,
		MUL_MAG_MAG,
		MUL_MID_MID,
		MUL_MID2_P
	} mul_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK,
		S_TW_SET,
		S_TW_RUN,
		S_TW_DRAIN,
		S_VT_M1,
		S_VT_M2,
		S_PL_INIT,
		S_IW_SET,
		S_IW_RUN,
		S_IW_DRAIN,
		S_VI_M1,
		S_VI_M2,
		S_MG_M1,
		S_MG_M2,
		S_SC_CHK,
		S_P_M,
		S_R_M,
		S_BS_LOOP,
		S_BS_M1,
		S_BS_M2,
		S_UPD,
		S_MWAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic     walk_start;
		logic     walk_tmpl;
		logic     walk_step;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     place_init;
		logic     place_next;
		logic     bs_init;
		logic     best_upd;
	} ncc_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic no_place;
		logic walk_last;
		logic mul_done;
		logic zero_case;
		logic bs_more;
		logic place_last;
	} ncc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ncc_ram.sv =====
`default_nettype none
module ncc_ram #(
	parameter int W = 8,
	parameter int D = 256,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [W-1:0]  wdata,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== rtl/ncc_mul.sv =====
`default_nettype none
module ncc_mul #(
	parameter int AW = 80,
	parameter int BW = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic                  done,
	output logic [AW+BW-1:0]      prod
);

	localparam int PW = AW + BW;

	logic          busy_q;
	logic          done_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] ash_q;
	logic [BW-1:0] bsh_q;

	// control: runs until the multiplier bits are used up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bsh_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift and add, one multiplier bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= PW'(a);
			bsh_q <= b;
		end else if (busy_q && bsh_q != '0) begin
			if (bsh_q[0]) begin
				acc_q <= acc_q + ash_q;
			end
			ash_q <= ash_q << 1;
			bsh_q <= bsh_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ===== rtl/ncc_dp.sv =====
`default_nettype none
module ncc_dp import ncc_pkg::*; #(
	parameter int MAX_TEMPLATE_ROWS = DEF_MAX_TEMPLATE_ROWS,
	parameter int MAX_TEMPLATE_COLS = DEF_MAX_TEMPLATE_COLS,
	parameter int MAX_IMAGE_ROWS    = DEF_MAX_IMAGE_ROWS,
	parameter int MAX_IMAGE_COLS    = DEF_MAX_IMAGE_COLS,
	parameter int WINDOW_RADIUS     = DEF_WINDOW_RADIUS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load_acc,
	input  wire logic              search_acc,
	input  wire ncc_in_t           item,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_idx,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire ncc_cmd_t          cmd,
	output ncc_stat_t              stat,
	output ncc_out_t               result
);

	localparam int TD  = MAX_TEMPLATE_ROWS * MAX_TEMPLATE_COLS;
	localparam int ID  = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
	localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
	localparam int IAW = (ID > 1) ? $clog2(ID) : 1;
	localparam int NW  = $clog2(TD + 1);
	localparam int SW  = NW + 8;
	localparam int SSW = NW + 16;
	localparam int VW  = 2 * NW + 16;
	localparam int PW  = 2 * VW;
	localparam int RW  = PW + RHS_SHIFT;
	localparam int BW  = (VW > 31) ? VW : 31;
	localparam int PRW = PW + BW;

	// configuration registers
	logic [6:0] trows_q, tcols_q;
	logic [8:0] irows_q, icols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trows_q <= 7'd64;
			tcols_q <= 7'd64;
			irows_q <= 9'd256;
			icols_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TROWS: trows_q <= cfg_data[6:0];
				CFG_TCOLS: tcols_q <= cfg_data[6:0];
				CFG_IROWS: irows_q <= cfg_data;
				CFG_ICOLS: icols_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// sizes clamped to the build limits
	logic [6:0]  tr_c, tc_c;
	logic [8:0]  ir_c, ic_c;
	logic [13:0] tcnt;
	logic [17:0] icnt;
	logic [NW-1:0] n;

	assign tr_c = (int'(trows_q) > MAX_TEMPLATE_ROWS) ? 7'(MAX_TEMPLATE_ROWS) : trows_q;
	assign tc_c = (int'(tcols_q) > MAX_TEMPLATE_COLS) ? 7'(MAX_TEMPLATE_COLS) : tcols_q;
	assign ir_c = (int'(irows_q) > MAX_IMAGE_ROWS) ? 9'(MAX_IMAGE_ROWS) : irows_q;
	assign ic_c = (int'(icols_q) > MAX_IMAGE_COLS) ? 9'(MAX_IMAGE_COLS) : icols_q;
	assign tcnt = 14'(tr_c) * 14'(tc_c);
	assign icnt = 18'(ir_c) * 18'(ic_c);
	assign n    = NW'(tcnt);

	// load indexes
	logic [TAW-1:0] tidx_q;
	logic [IAW-1:0] iidx_q;
	logic [TAW:0]   tnx;
	logic [IAW:0]   inx;
	logic           tload, iload;

	assign tload = load_acc && item.cmd == CMD_TMPL;
	assign iload = load_acc && item.cmd == CMD_IMG;
	assign tnx   = {1'b0, tidx_q} + 1'b1;
	assign inx   = {1'b0, iidx_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tidx_q <= '0;
			iidx_q <= '0;
		end else begin
			if (tload) begin
				tidx_q <= (32'(tnx) >= 32'(tcnt) || 32'(tnx) >= 32'(TD)) ? '0 : tnx[TAW-1:0];
			end
			if (iload) begin
				iidx_q <= (32'(inx) >= 32'(icnt) || 32'(inx) >= 32'(ID)) ? '0 : inx[IAW-1:0];
			end
		end
	end

	// search window from the hint
	logic signed [CW-1:0] maxr, maxc, hr, hc, rad, hrlo, hrhi, hclo, hchi;
	logic signed [CW-1:0] r0_d, r1_d, c0_d, c1_d;
	logic signed [CW-1:0] r0_q, r1_q, c0_q, c1_q;
	logic                 hint_nz, no_place_d, no_place_q;

	assign maxr    = $signed({2'b0, ir_c}) - $signed({4'b0, tr_c});
	assign maxc    = $signed({2'b0, ic_c}) - $signed({4'b0, tc_c});
	assign hr      = $signed({3'b0, item.hint_row});
	assign hc      = $signed({3'b0, item.hint_col});
	assign rad     = $signed(CW'(WINDOW_RADIUS));
	assign hrlo    = hr - rad;
	assign hrhi    = hr + rad;
	assign hclo    = hc - rad;
	assign hchi    = hc + rad;
	assign hint_nz = item.hint_row != 8'd0 || item.hint_col != 8'd0;
	assign r0_d    = (hint_nz && !hrlo[CW-1]) ? hrlo : '0;
	assign r1_d    = (hint_nz && hrhi <= maxr) ? hrhi : maxr;
	assign c0_d    = (hint_nz && !hclo[CW-1]) ? hclo : '0;
	assign c1_d    = (hint_nz && hchi <= maxc) ? hchi : maxc;
	assign no_place_d = maxr[CW-1] || maxc[CW-1] || (r0_d > r1_d) || (c0_d > c1_d);

	always_ff @(posedge clk) begin
		if (search_acc) begin
			r0_q       <= r0_d;
			r1_q       <= r1_d;
			c0_q       <= c0_d;
			c1_q       <= c1_d;
			no_place_q <= no_place_d;
		end
	end

	// placement counters
	logic signed [CW-1:0] i_q, j_q;

	always_ff @(posedge clk) begin
		if (cmd.place_init) begin
			i_q <= r0_q;
			j_q <= c0_q;
		end else if (cmd.place_next) begin
			if (j_q == c1_q) begin
				j_q <= c0_q;
				i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// pixel walk address generator
	logic [18:0]    base_full;
	logic [6:0]     k_q, l_q;
	logic [TAW-1:0] taddr_q;
	logic [IAW-1:0] iaddr_q, rowb_q, icw;
	logic           wtm_q;

	assign base_full = 19'(i_q[9:0]) * 19'(ic_c) + 19'(j_q[9:0]);
	assign icw       = IAW'(ic_c);

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			k_q     <= '0;
			l_q     <= '0;
			taddr_q <= '0;
			iaddr_q <= IAW'(base_full);
			rowb_q  <= IAW'(base_full);
			wtm_q   <= cmd.walk_tmpl;
		end else if (cmd.walk_step) begin
			taddr_q <= taddr_q + 1'b1;
			if (l_q == tc_c - 7'd1) begin
				l_q     <= '0;
				k_q     <= k_q + 7'd1;
				rowb_q  <= rowb_q + icw;
				iaddr_q <= rowb_q + icw;
			end else begin
				l_q     <= l_q + 7'd1;
				iaddr_q <= iaddr_q + 1'b1;
			end
		end
	end

	// pixel stores
	logic [7:0] tpix, ipix;

	ncc_ram #(.W(8), .D(TD), .AW(TAW)) u_tram (
		.clk   (clk),
		.we    (tload),
		.addr  (cmd.walk_step ? taddr_q : tidx_q),
		.wdata (item.pixel),
		.rdata (tpix)
	);

	ncc_ram #(.W(8), .D(ID), .AW(IAW)) u_iram (
		.clk   (clk),
		.we    (iload),
		.addr  (cmd.walk_step ? iaddr_q : iidx_q),
		.wdata (item.pixel),
		.rdata (ipix)
	);

	// read data arrives in the cycle after the address
	logic rd_s1, tm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			tm_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.walk_step;
			tm_s1 <= wtm_q;
		end
	end

	// running sums
	logic [SW-1:0]  st_q, si_q;
	logic [SSW-1:0] stt_q, sii_q, sti_q;

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			if (cmd.walk_tmpl) begin
				st_q  <= '0;
				stt_q <= '0;
			end else begin
				si_q  <= '0;
				sii_q <= '0;
				sti_q <= '0;
			end
		end else if (rd_s1) begin
			if (tm_s1) begin
				st_q  <= st_q + SW'(tpix);
				stt_q <= stt_q + SSW'(16'(tpix) * 16'(tpix));
			end else begin
				si_q  <= si_q + SW'(ipix);
				sii_q <= sii_q + SSW'(16'(ipix) * 16'(ipix));
				sti_q <= sti_q + SSW'(16'(ipix) * 16'(tpix));
			end
		end
	end

	// shared multiplier and its operand select
	logic [PW-1:0]  mul_a;
	logic [BW-1:0]  mul_b;
	logic [PRW-1:0] prod;
	logic           mul_done;
	mul_sel_t       sel_q;
	logic [VW-1:0]  a_q, vt_q, vi_q, mag_q, prodv;
	logic [PW-1:0]  p_q;
	logic [RW-1:0]  rhs_q;
	logic [30:0]    m2_q;
	logic [15:0]    lo_q, hi_q, mid;
	logic [16:0]    mid_sum;

	assign mid_sum = 17'(lo_q) + 17'(hi_q) + 17'd1;
	assign mid     = mid_sum[16:1];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_N_STT:   begin mul_a = PW'(stt_q); mul_b = BW'(n);     end
			MUL_ST_ST:   begin mul_a = PW'(st_q);  mul_b = BW'(st_q);  end
			MUL_N_SII:   begin mul_a = PW'(sii_q); mul_b = BW'(n);     end
			MUL_SI_SI:   begin mul_a = PW'(si_q);  mul_b = BW'(si_q);  end
			MUL_N_STI:   begin mul_a = PW'(sti_q); mul_b = BW'(n);     end
			MUL_ST_SI:   begin mul_a = PW'(si_q);  mul_b = BW'(st_q);  end
			MUL_VT_VI:   begin mul_a = PW'(vt_q);  mul_b = BW'(vi_q);  end
			MUL_MAG_MAG: begin mul_a = PW'(mag_q); mul_b = BW'(mag_q); end
			MUL_MID_MID: begin mul_a = PW'(mid);   mul_b = BW'(mid);   end
			MUL_MID2_P:  begin mul_a = p_q;        mul_b = BW'(m2_q);  end
			default:     ;
		endcase
	end

	ncc_mul #(.AW(PW), .BW(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	assign prodv = prod[VW-1:0];

	// product write-back and score search
	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			sel_q <= cmd.mul_sel;
		end
		if (cmd.bs_init) begin
			lo_q <= '0;
			hi_q <= 16'(SCORE_ONE);
		end
		if (mul_done) begin
			case (sel_q)
				MUL_N_STT, MUL_N_SII, MUL_N_STI: a_q <= prodv;
				MUL_ST_ST:   vt_q  <= (a_q > prodv) ? a_q - prodv : '0;
				MUL_SI_SI:   vi_q  <= (a_q > prodv) ? a_q - prodv : '0;
				MUL_ST_SI:   mag_q <= (a_q >= prodv) ? a_q - prodv : prodv - a_q;
				MUL_VT_VI:   p_q   <= prod[PW-1:0];
				MUL_MAG_MAG: rhs_q <= {prod[PW-1:0], {RHS_SHIFT{1'b0}}};
				MUL_MID_MID: m2_q  <= prod[30:0];
				MUL_MID2_P: begin
					if (prod <= PRW'(rhs_q)) begin
						lo_q <= mid;
					end else begin
						hi_q <= mid - 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// best placement so far
	logic        zero_case;
	logic [15:0] score;
	logic [7:0]  best_r_q, best_c_q;
	logic [15:0] best_s_q;

	assign zero_case = vt_q == '0 || vi_q == '0 || mag_q == '0;
	assign score     = zero_case ? 16'd0 : lo_q;

	always_ff @(posedge clk) begin
		if (search_acc) begin
			best_r_q <= '0;
			best_c_q <= '0;
			best_s_q <= '0;
		end else if (cmd.best_upd && score > best_s_q) begin
			best_r_q <= i_q[7:0];
			best_c_q <= j_q[7:0];
			best_s_q <= score;
		end
	end

	// status back to the controller
	assign stat.n_zero     = tr_c == 7'd0 || tc_c == 7'd0;
	assign stat.no_place   = no_place_q;
	assign stat.walk_last  = (k_q == tr_c - 7'd1) && (l_q == tc_c - 7'd1);
	assign stat.mul_done   = mul_done;
	assign stat.zero_case  = zero_case;
	assign stat.bs_more    = lo_q < hi_q;
	assign stat.place_last = (i_q == r1_q) && (j_q == c1_q);

	// result fields
	assign result.best_row   = best_r_q;
	assign result.best_col   = best_c_q;
	assign result.center_row = best_r_q + {2'b0, tr_c[6:1]};
	assign result.center_col = best_c_q + {2'b0, tc_c[6:1]};
	assign result.best_score = best_s_q;

endmodule
`default_nettype wire

// ===== rtl/ncc_ctrl.sv =====
`default_nettype none
module ncc_ctrl import ncc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      go,
	input  wire ncc_stat_t stat,
	output ncc_cmd_t       cmd,
	output logic           busy,
	output logic           done
);

	state_t state_q, state_d, ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			if (cmd.mul_start) begin
				ret_q <= ret_d;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (go) state_d = S_CHK;
			S_CHK:      state_d = (stat.n_zero || stat.no_place) ? S_OUT : S_TW_SET;
			S_TW_SET:   state_d = S_TW_RUN;
			S_TW_RUN:   if (stat.walk_last) state_d = S_TW_DRAIN;
			S_TW_DRAIN: state_d = S_VT_M1;
			S_PL_INIT:  state_d = S_IW_SET;
			S_IW_SET:   state_d = S_IW_RUN;
			S_IW_RUN:   if (stat.walk_last) state_d = S_IW_DRAIN;
			S_IW_DRAIN: state_d = S_VI_M1;
			S_SC_CHK:   state_d = stat.zero_case ? S_UPD : S_P_M;
			S_BS_LOOP:  state_d = stat.bs_more ? S_BS_M1 : S_UPD;
			S_VT_M1, S_VT_M2, S_VI_M1, S_VI_M2, S_MG_M1, S_MG_M2,
			S_P_M, S_R_M, S_BS_M1, S_BS_M2: state_d = S_MWAIT;
			S_MWAIT:    if (stat.mul_done) state_d = ret_q;
			S_UPD:      state_d = stat.place_last ? S_OUT : S_IW_SET;
			S_OUT:      state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd   = '0;
		ret_d = S_IDLE;
		case (state_q)
			S_TW_SET: begin
				cmd.walk_start = 1'b1;
				cmd.walk_tmpl  = 1'b1;
			end
			S_TW_RUN, S_IW_RUN: cmd.walk_step = 1'b1;
			S_VT_M1: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_N_STT; ret_d = S_VT_M2;
			end
			S_VT_M2: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_ST_ST; ret_d = S_PL_INIT;
			end
			S_PL_INIT: cmd.place_init = 1'b1;
			S_IW_SET:  cmd.walk_start = 1'b1;
			S_VI_M1: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_N_SII; ret_d = S_VI_M2;
			end
			S_VI_M2: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_SI_SI; ret_d = S_MG_M1;
			end
			S_MG_M1: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_N_STI; ret_d = S_MG_M2;
			end
			S_MG_M2: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_ST_SI; ret_d = S_SC_CHK;
			end
			S_P_M: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_VT_VI; ret_d = S_R_M;
			end
			S_R_M: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_MAG_MAG; ret_d = S_BS_LOOP;
				cmd.bs_init   = 1'b1;
			end
			S_BS_M1: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_MID_MID; ret_d = S_BS_M2;
			end
			S_BS_M2: begin
				cmd.mul_start = 1'b1; cmd.mul_sel = MUL_MID2_P; ret_d = S_BS_LOOP;
			end
			S_UPD: begin
				cmd.best_upd   = 1'b1;
				cmd.place_next = !stat.place_last;
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

endmodule
`default_nettype wire

// ===== rtl/ncc_template_match_search_unit.sv =====
`default_nettype none
// Normalized cross-correlation template search.
// Input beat: taken on a rising edge with start high and busy low. cmd selects
// a template pixel load, an image pixel load (raster order, one beat a cycle,
// busy stays low) or a search with a hint position; a hint of zero searches
// every placement, any other hint a window around it.
// Result beat: one per search, on result for the single cycle done is high;
// the receiver cannot stall, so nothing is held back.
// Configuration: cfg_we/cfg_idx/cfg_data write template and image sizes; the user
// must write them only while the block is idle, the block does not enforce it.
// A search with no placements or an empty template goes from the check state
// straight to the output state. The pixel walk reads one template and one image
// pixel per cycle from the single-port stores; the score is a bit-serial
// shift-add multiplier driving a 16-step binary search. busy stays high until
// the cycle after done; the next beat is taken then.
// Reset clears the sizes to a 64 by 64 template and a 256 by 256 image, the load
// positions to zero and the controller to idle; store contents are undefined
// until loaded.
module ncc_template_match_search_unit import ncc_pkg::*; #(
	parameter int MAX_TEMPLATE_ROWS = DEF_MAX_TEMPLATE_ROWS,
	parameter int MAX_TEMPLATE_COLS = DEF_MAX_TEMPLATE_COLS,
	parameter int MAX_IMAGE_ROWS    = DEF_MAX_IMAGE_ROWS,
	parameter int MAX_IMAGE_COLS    = DEF_MAX_IMAGE_COLS,
	parameter int WINDOW_RADIUS     = DEF_WINDOW_RADIUS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire ncc_in_t           item,
	output logic                   done,
	output ncc_out_t               result,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_idx,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	logic      accept, search_acc;
	ncc_cmd_t  cmd;
	ncc_stat_t stat;

	// beat acceptance
	assign accept     = start && !busy;
	assign search_acc = accept && item.cmd == CMD_SEARCH;

	ncc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (search_acc),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ncc_dp #(
		.MAX_TEMPLATE_ROWS (MAX_TEMPLATE_ROWS),
		.MAX_TEMPLATE_COLS (MAX_TEMPLATE_COLS),
		.MAX_IMAGE_ROWS    (MAX_IMAGE_ROWS),
		.MAX_IMAGE_COLS    (MAX_IMAGE_COLS),
		.WINDOW_RADIUS     (WINDOW_RADIUS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_acc   (accept),
		.search_acc (search_acc),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.stat       (stat),
		.result     (result)
	);

endmodule
`default_nettype wire

// ===== rtl/ncc_chk.sv =====
`default_nettype none
module ncc_chk import ncc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire ncc_in_t           item,
	input wire logic              done,
	input wire ncc_out_t          result
);

	// a search beat makes the block busy
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_SEARCH) |=> busy)
		else $error("search beat did not raise busy");

	// a load or unused beat leaves the block ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd != CMD_SEARCH) |=> !busy)
		else $error("load beat raised busy");

	// a result only appears while a search runs
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result without a search");

	// the block is ready right after its result
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block not ready after result");

	// score never exceeds one
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.best_score <= 16'd32768))
		else $error("score above one");

endmodule

bind ncc_template_match_search_unit ncc_chk u_chk (.*);
`default_nettype wire

// ===== dv/ncc_template_match_search_unit_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module ncc_template_match_search_unit_test;
	import ncc_pkg::*;

	localparam int T_MAX_R = DEF_MAX_TEMPLATE_ROWS;
	localparam int T_MAX_C = DEF_MAX_TEMPLATE_COLS;
	localparam int I_MAX_R = DEF_MAX_IMAGE_ROWS;
	localparam int I_MAX_C = DEF_MAX_IMAGE_COLS;
	localparam int RADIUS  = DEF_WINDOW_RADIUS;
	localparam int T_DEPTH = T_MAX_R * T_MAX_C;
	localparam int I_DEPTH = I_MAX_R * I_MAX_C;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	ncc_in_t           item;
	logic              done;
	ncc_out_t          result;
	logic              cfg_we;
	logic [1:0]        cfg_idx;
	logic [CFG_DW-1:0] cfg_data;

	ncc_template_match_search_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// mirror of the block state
	logic [7:0] tmpl_mem [T_DEPTH];
	logic [7:0] img_mem [I_DEPTH];
	bit         tmpl_seen [T_DEPTH];
	bit         img_seen [I_DEPTH];
	int         tmpl_ptr, img_ptr;
	int         reg_trows, reg_tcols, reg_irows, reg_icols;

	ncc_out_t   pending_matches[$];
	int         errors;
	longint     cyc;
	longint     cycle_limit;

	// stimulus shaping
	int  pix_mode;
	bit  embed_on;
	int  embed_r, embed_c;
	bit  idle_on;

	// directed table
	typedef struct {
		ncc_in_t  beat;
		bit       typed;
		ncc_out_t want;
	} dir_row_t;
	dir_row_t dir_tab[$];

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int clampi(int v, int hi);
		return (v > hi) ? hi : v;
	endfunction

	function automatic int tr_use(); return clampi(reg_trows, T_MAX_R); endfunction
	function automatic int tc_use(); return clampi(reg_tcols, T_MAX_C); endfunction
	function automatic int ir_use(); return clampi(reg_irows, I_MAX_R); endfunction
	function automatic int ic_use(); return clampi(reg_icols, I_MAX_C); endfunction

	// floor(32768 * mag / sqrt(vt * vi)) by binary search on squares
	function automatic int unsigned q15_magnitude(longint unsigned mag,
			longint unsigned vt, longint unsigned vi);
		bit [127:0]  prod, rhs, lhs;
		int unsigned lo, hi, mid;
		if (vt == 0 || vi == 0 || mag == 0)
			return 0;
		prod = 128'(vt) * 128'(vi);
		rhs = (128'(mag) * 128'(mag)) << RHS_SHIFT;
		lo = 0;
		hi = SCORE_ONE;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = 128'(mid) * 128'(mid) * prod;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// best placement by normalized cross-correlation
	function automatic ncc_out_t best_match(int hr, int hc, output int places);
		int              tr, tc, ir, ic, maxr, maxc, r0, r1, c0, c1;
		int              best_r, best_c;
		int unsigned     best_s, s;
		longint unsigned n, st, stt, a, b, vt, si, sii, sti, vi, mag, p, t;
		ncc_out_t        o;
		tr = tr_use(); tc = tc_use(); ir = ir_use(); ic = ic_use();
		n = tr * tc;
		st = 0; stt = 0;
		for (int k = 0; k < tr; k++)
			for (int l = 0; l < tc; l++) begin
				t = tmpl_mem[k * tc + l];
				st += t;
				stt += t * t;
			end
		a = n * stt; b = st * st;
		vt = (a > b) ? a - b : 0;
		maxr = ir - tr; maxc = ic - tc;
		r0 = 0; r1 = maxr; c0 = 0; c1 = maxc;
		if (hr != 0 || hc != 0) begin
			if (hr - RADIUS >= 0) r0 = hr - RADIUS;
			if (hr + RADIUS <= maxr) r1 = hr + RADIUS;
			if (hc - RADIUS >= 0) c0 = hc - RADIUS;
			if (hc + RADIUS <= maxc) c1 = hc + RADIUS;
		end
		best_r = 0; best_c = 0; best_s = 0; places = 0;
		if (maxr >= 0 && maxc >= 0)
			for (int i = r0; i <= r1; i++)
				for (int j = c0; j <= c1; j++) begin
					si = 0; sii = 0; sti = 0;
					places++;
					for (int k = 0; k < tr; k++)
						for (int l = 0; l < tc; l++) begin
							p = img_mem[(i + k) * ic + j + l];
							t = tmpl_mem[k * tc + l];
							si += p;
							sii += p * p;
							sti += p * t;
						end
					a = n * sii; b = si * si;
					vi = (a > b) ? a - b : 0;
					a = n * sti; b = st * si;
					mag = (a >= b) ? a - b : b - a;
					s = q15_magnitude(mag, vt, vi);
					if (s > best_s) begin
						best_s = s; best_r = i; best_c = j;
					end
				end
		o.best_row = best_r[7:0];
		o.best_col = best_c[7:0];
		o.center_row = 8'(best_r + tr / 2);
		o.center_col = 8'(best_c + tc / 2);
		o.best_score = best_s[15:0];
		return o;
	endfunction

	// advance the mirror for one accepted beat
	task automatic take_beat(ncc_in_t b, bit typed, ncc_out_t want);
		int       cnt, places;
		ncc_out_t got;
		case (b.cmd)
			CMD_TMPL: begin
				cnt = tr_use() * tc_use();
				tmpl_mem[tmpl_ptr] = b.pixel;
				tmpl_seen[tmpl_ptr] = 1'b1;
				tmpl_ptr = (tmpl_ptr + 1 >= cnt || tmpl_ptr + 1 >= T_DEPTH) ? 0 : tmpl_ptr + 1;
				cycle_limit += 40;
			end
			CMD_IMG: begin
				cnt = ir_use() * ic_use();
				img_mem[img_ptr] = b.pixel;
				img_seen[img_ptr] = 1'b1;
				img_ptr = (img_ptr + 1 >= cnt || img_ptr + 1 >= I_DEPTH) ? 0 : img_ptr + 1;
				cycle_limit += 40;
			end
			CMD_SEARCH: begin
				got = best_match(b.hint_row, b.hint_col, places);
				pending_matches.push_back(typed ? want : got);
				cnt = tr_use() * tc_use();
				cycle_limit += 4 * (cnt + 8 + places * (cnt + 1300)) + 200;
			end
			default: cycle_limit += 40;
		endcase
	endtask

	// drive one beat and wait for it to be taken
	task automatic send_beat(ncc_in_t b, bit typed, ncc_out_t want);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		take_beat(b, typed, want);
	endtask

	task automatic send_plain(ncc_in_t b);
		send_beat(b, 1'b0, '0);
	endtask

	// sender holds off until every search has reported
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_matches.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_TROWS: reg_trows = val & 8'h7f;
			CFG_TCOLS: reg_tcols = val & 8'h7f;
			CFG_IROWS: reg_irows = val & 12'h1ff;
			default:   reg_icols = val & 12'h1ff;
		endcase
	endtask

	task automatic set_sizes(int tr, int tc, int ir, int ic);
		drain();
		write_reg(CFG_TROWS, tr);
		write_reg(CFG_TCOLS, tc);
		write_reg(CFG_IROWS, ir);
		write_reg(CFG_ICOLS, ic);
	endtask

	function automatic logic [7:0] rand_pixel();
		case (pix_mode)
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(0, 1));
			default: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
		endcase
	endfunction

	// image pixel for the next load address, template planted when enabled
	function automatic logic [7:0] image_pixel(int addr);
		int r, c;
		r = addr / ic_use();
		c = addr % ic_use();
		if (embed_on && r >= embed_r && r < embed_r + tr_use() &&
				c >= embed_c && c < embed_c + tc_use())
			return tmpl_mem[(r - embed_r) * tc_use() + (c - embed_c)];
		return rand_pixel();
	endfunction

	function automatic bit tmpl_full();
		for (int a = 0; a < tr_use() * tc_use(); a++)
			if (!tmpl_seen[a]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit img_full();
		for (int a = 0; a < ir_use() * ic_use(); a++)
			if (!img_seen[a]) return 1'b0;
		return 1'b1;
	endfunction

	// fresh template and image for the current sizes
	task automatic load_stores();
		ncc_in_t b;
		b = '0;
		b.cmd = CMD_TMPL;
		for (int k = 0; k < tr_use() * tc_use() || !tmpl_full(); k++) begin
			b.pixel = rand_pixel();
			send_plain(b);
		end
		embed_on = (ir_use() >= tr_use() && ic_use() >= tc_use()) && $urandom_range(0, 3) != 0;
		if (embed_on) begin
			embed_r = $urandom_range(0, ir_use() - tr_use());
			embed_c = $urandom_range(0, ic_use() - tc_use());
		end
		b.cmd = CMD_IMG;
		for (int k = 0; k < ir_use() * ic_use() || !img_full(); k++) begin
			b.pixel = image_pixel(img_ptr);
			send_plain(b);
		end
	endtask

	// random beats: mostly image and template loads, some searches over loaded stores and noise
	task automatic random_beats(int count);
		ncc_in_t b;
		int      sel, maxr, maxc, nt, full_cost;
		maxr = ir_use() - tr_use();
		maxc = ic_use() - tc_use();
		nt = tr_use() * tc_use();
		full_cost = (maxr >= 0 && maxc >= 0) ? (maxr + 1) * (maxc + 1) * (nt + 1300) : 0;
		for (int k = 0; k < count; k++) begin
			b = '0;
			b.pixel = 8'($urandom_range(0, 255));
			b.hint_row = 8'($urandom_range(0, 255));
			b.hint_col = 8'($urandom_range(0, 255));
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				b.cmd = CMD_SEARCH;
				if ($urandom_range(0, 4) == 0 && full_cost < 40000) begin
					b.hint_row = 0;
					b.hint_col = 0;
				end else begin
					if ($urandom_range(0, 3) != 0)
						b.hint_row = 8'($urandom_range(0, clampi(maxr + 3, 255)));
					if ($urandom_range(0, 3) != 0)
						b.hint_col = 8'($urandom_range(0, clampi(maxc + 3, 255)));
					if (b.hint_row == 0 && b.hint_col == 0 && full_cost >= 40000)
						b.hint_col = 8'd1;
				end
			end else if (sel < 31) begin
				b.cmd = CMD_UNUSED;
			end else if (sel < 50) begin
				b.cmd = CMD_TMPL;
				b.pixel = rand_pixel();
			end else begin
				b.cmd = CMD_IMG;
				b.pixel = image_pixel(img_ptr);
			end
			send_plain(b);
		end
	endtask

	task automatic run_phase(int tr, int tc, int ir, int ic, int count);
		set_sizes(tr, tc, ir, ic);
		pix_mode = $urandom_range(0, 5) == 0 ? 1 : ($urandom_range(0, 5) == 0 ? 2 : 0);
		load_stores();
		random_beats(count);
	endtask

	task automatic add_row(logic [1:0] cmd, int pix, int hr, int hc, bit typed,
			int br, int bc, int cr, int cc, int sc);
		dir_row_t r;
		r.beat.cmd = cmd;
		r.beat.pixel = 8'(pix);
		r.beat.hint_row = 8'(hr);
		r.beat.hint_col = 8'(hc);
		r.typed = typed;
		r.want.best_row = 8'(br);
		r.want.best_col = 8'(bc);
		r.want.center_row = 8'(cr);
		r.want.center_col = 8'(cc);
		r.want.best_score = 16'(sc);
		dir_tab.push_back(r);
	endtask

	// result checking
	task automatic field_mismatch(string name, int want, int got);
		$display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		ncc_out_t e;
		cyc <= cyc + 1;
		if (cyc > cycle_limit) begin
			$display("[ncc_template_match_search_unit] ERROR");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_matches.size() == 0) begin
				$display("%0t unexpected result beat: actual %p", $time, result);
				errors++;
			end else begin
				e = pending_matches.pop_front();
				if (result.best_row !== e.best_row)
					field_mismatch("best_row", e.best_row, result.best_row);
				if (result.best_col !== e.best_col)
					field_mismatch("best_col", e.best_col, result.best_col);
				if (result.center_row !== e.center_row)
					field_mismatch("center_row", e.center_row, result.center_row);
				if (result.center_col !== e.center_col)
					field_mismatch("center_col", e.center_col, result.center_col);
				if (result.best_score !== e.best_score)
					field_mismatch("best_score", e.best_score, result.best_score);
			end
		end
	end

	initial begin
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_TROWS;
		cfg_data = '0;
		arst_n = 1'b0;
		errors = 0;
		cyc = 0;
		cycle_limit = 200000;
		tmpl_ptr = 0;
		img_ptr = 0;
		reg_trows = 64; reg_tcols = 64; reg_irows = 256; reg_icols = 256;
		pix_mode = 0;
		embed_on = 1'b0;
		idle_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x2 template over a 3x3 image, exact match at (1,1)
		set_sizes(2, 2, 3, 3);
		add_row(CMD_TMPL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_TMPL, 255, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_TMPL, 255, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_TMPL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 7, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 3, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 9, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 255, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 5, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 255, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_IMG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// full search finds the planted copy
		add_row(CMD_SEARCH, 0, 0, 0, 1, 1, 1, 2, 2, SCORE_ONE);
		// window clipped away entirely
		add_row(CMD_SEARCH, 0, 255, 255, 1, 0, 0, 1, 1, 0);
		// unknown command is ignored
		add_row(CMD_UNUSED, 170, 85, 170, 0, 0, 0, 0, 0, 0);
		// window clipped at the low edge
		add_row(CMD_SEARCH, 0, 1, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_SEARCH, 0, 0, 1, 0, 0, 0, 0, 0, 0);
		// flat template has no variance
		add_row(CMD_TMPL, 128, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_TMPL, 128, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_TMPL, 128, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_TMPL, 128, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_SEARCH, 0, 0, 0, 1, 0, 0, 1, 1, 0);
		foreach (dir_tab[i])
			send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

		// random phases over several sizes, extremes included
		run_phase(3, 3, 6, 7, 40);
		run_phase(1, 64, 1, 65, 15);
		run_phase(1, 1, 4, 1, 20);
		run_phase(4, 2, 3, 8, 30);
		idle_on = 1'b0;
		run_phase(2, 3, 5, 5, 70);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[ncc_template_match_search_unit] OK");
		else
			$display("[ncc_template_match_search_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/ncc_pkg.sv
rtl/ncc_ram.sv
rtl/ncc_mul.sv
rtl/ncc_dp.sv
rtl/ncc_ctrl.sv
rtl/ncc_template_match_search_unit.sv
rtl/ncc_chk.sv
dv/ncc_template_match_search_unit_test.sv
